### design/psched_pkg.sv
package psched_pkg;

    localparam int MAX_PROCS_DEF = 64;

    localparam int MODE_W = 2;
    localparam int ID_W   = 16;
    localparam int TIN_W  = 16;
    localparam int NOW_W  = 23;
    localparam int EV_W   = 2;
    localparam int POL_W  = 2;
    localparam int QNT_W  = 16;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    localparam logic [NOW_W-1:0] TIME_MAX = {NOW_W{1'b1}};

    // Input item modes.
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    // Result event codes.
    localparam logic [EV_W-1:0] EV_IDLE    = 2'd0;
    localparam logic [EV_W-1:0] EV_RUN     = 2'd1;
    localparam logic [EV_W-1:0] EV_FINISH  = 2'd2;
    localparam logic [EV_W-1:0] EV_ALLDONE = 2'd3;

    // Scheduling policies.
    localparam logic [POL_W-1:0] POL_FCFS = 2'd0;
    localparam logic [POL_W-1:0] POL_RR   = 2'd1;
    localparam logic [POL_W-1:0] POL_SRTF = 2'd2;

    // Register indexes (bit 2 of the byte address).
    localparam logic REG_POLICY  = 1'b0;
    localparam logic REG_QUANTUM = 1'b1;

endpackage

### design/psched_if.sv
interface psched_req_if import psched_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ID_W-1:0]   proc_id;
    logic [TIN_W-1:0]  arrival;
    logic [TIN_W-1:0]  burst;

    modport source (output valid, mode, proc_id, arrival, burst, input ready);
    modport sink   (input valid, mode, proc_id, arrival, burst, output ready);
endinterface

interface psched_rsp_if import psched_pkg::*;;
    logic             valid;
    logic             ready;
    logic [EV_W-1:0]  event_res;
    logic [ID_W-1:0]  run_id;
    logic [NOW_W-1:0] now;

    modport source (output valid, event_res, run_id, now, input ready);
    modport sink   (input valid, event_res, run_id, now, output ready);
endinterface

### design/process_scheduler_tick.sv
// Channel   Dir   Handshake      Payload
// req       in    valid/ready    mode, proc_id, arrival, burst
// rsp       out   valid/ready    event_res, run_id, now
// apb       in    psel/penable   paddr, pwdata -> prdata (policy at 0x0, quantum at 0x4)
//
// Load, clear and ignored items are handled in the idle state. A tick with work left
// scans the process table through its single read port before its result is set.
// rst_n is asynchronous and active low; the process table needs no clearing pass.
// A finished result waits in the output register while the next item is accepted;
// a tick whose result is ready holds in its last state until that register frees up.
module process_scheduler_tick
    import psched_pkg::*;
#(
    parameter int MAX_PROCS = MAX_PROCS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    psched_req_if.sink        req,
    psched_rsp_if.source      rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DEC, S_OUT} state_t;

    // Process table. Only entries below the entry count are ever read, so the
    // arrays need no reset. The arrived flag of the table is not stored: system
    // time only grows between clears, so an entry has arrived exactly when its
    // arrival time is at or below the current time.
    logic [ID_W-1:0]  ids_mem  [MAX_PROCS];
    logic [TIN_W-1:0] arr_mem  [MAX_PROCS];
    logic [TIN_W-1:0] rem_mem  [MAX_PROCS];

    state_t           state_reg,    state_next;
    logic [POL_W-1:0] policy_reg,   policy_next;
    logic [QNT_W-1:0] quantum_reg,  quantum_next;
    logic [CNT_W-1:0] ent_cnt_reg,  ent_cnt_next;
    logic [CNT_W-1:0] unf_reg,      unf_next;
    logic [NOW_W-1:0] sys_time_reg, sys_time_next;
    logic [IDX_W-1:0] cursor_reg,   cursor_next;
    logic [QNT_W-1:0] slice_reg,    slice_next;

    // Scan sequencer.
    logic [IDX_W-1:0] scan_addr_reg, scan_addr_next;
    logic [CNT_W-1:0] scan_cnt_reg,  scan_cnt_next;
    logic             rd_valid_reg,  rd_valid_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic [ID_W-1:0]  rd_id_reg;
    logic [TIN_W-1:0] rd_arr_reg;
    logic [TIN_W-1:0] rd_rem_reg;
    logic             found_reg,     found_next;
    logic [IDX_W-1:0] best_idx_reg,  best_idx_next;
    logic [ID_W-1:0]  best_id_reg,   best_id_next;
    logic [TIN_W-1:0] best_rem_reg,  best_rem_next;

    // Result held for the output register.
    logic [EV_W-1:0]  res_ev_reg,    res_ev_next;
    logic [ID_W-1:0]  res_id_reg,    res_id_next;
    logic [NOW_W-1:0] res_now_reg,   res_now_next;
    logic             out_valid_reg, out_valid_next;
    logic [EV_W-1:0]  out_ev_reg,    out_ev_next;
    logic [ID_W-1:0]  out_id_reg,    out_id_next;
    logic [NOW_W-1:0] out_now_reg,   out_now_next;

    // Table port controls.
    logic             load_we;
    logic             rem_we;
    logic [IDX_W-1:0] wr_addr;
    logic [TIN_W-1:0] rem_wdata;
    logic             rd_en;

    // Helper signals.
    logic             req_fire;
    logic             cfg_we;
    logic             scan_issue;
    logic [QNT_W-1:0] q_eff;
    logic             cur_ok;
    logic [IDX_W-1:0] cursor_a;
    logic [QNT_W-1:0] slice_a;
    logic [IDX_W-1:0] cur_prep;
    logic [QNT_W-1:0] slice_prep;
    logic             rd_arrived;
    logic             rd_take;
    logic [TIN_W-1:0] rem_dec;
    logic [QNT_W:0]   slice_inc;
    logic [NOW_W-1:0] time_adv;

    // Index of the next table entry in round robin order, wrapping at the fill level.
    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx,
                                                  input logic [CNT_W-1:0] cnt);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(idx) + (CNT_W+1)'(1);
        if (sum >= (CNT_W+1)'(cnt))
            return '0;
        return IDX_W'(sum);
    endfunction

    assign req_fire  = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign cfg_we    = psel && penable && pwrite;
    assign pready    = 1'b1;

    assign rsp.valid     = out_valid_reg;
    assign rsp.event_res = out_ev_reg;
    assign rsp.run_id    = out_id_reg;
    assign rsp.now       = out_now_reg;

    always_comb
    begin
        case (paddr[2])
            REG_POLICY:  prdata = DATA_W'(policy_reg);
            REG_QUANTUM: prdata = DATA_W'(quantum_reg);
            default:     prdata = '0;
        endcase
    end

    // Round robin slice bookkeeping done at the start of a tick: a cursor past the
    // table restarts at entry zero, and a used-up slice rotates to the next entry.
    assign q_eff    = (quantum_reg == '0) ? QNT_W'(1) : quantum_reg;
    assign cur_ok   = (CNT_W'(cursor_reg) < ent_cnt_reg);
    assign cursor_a = cur_ok ? cursor_reg : '0;
    assign slice_a  = cur_ok ? slice_reg : '0;

    always_comb
    begin
        if (slice_a >= q_eff)
        begin
            cur_prep   = wrap_inc(cursor_a, ent_cnt_reg);
            slice_prep = '0;
        end
        else
        begin
            cur_prep   = cursor_a;
            slice_prep = slice_a;
        end
    end

    assign scan_issue = (scan_cnt_reg != ent_cnt_reg);
    assign rd_arrived = (NOW_W'(rd_arr_reg) <= sys_time_reg);

    // Candidate test for the entry whose data has just come back from the table.
    // First come first served ignores arrival; shortest remaining time keeps the
    // lowest index on a tie by taking only a strictly smaller value.
    always_comb
    begin
        case (policy_reg)
            POL_RR:   rd_take = !found_reg && (rd_rem_reg != '0) && rd_arrived;
            POL_SRTF: rd_take = (rd_rem_reg != '0) && rd_arrived &&
                                (!found_reg || (rd_rem_reg < best_rem_reg));
            default:  rd_take = !found_reg && (rd_rem_reg != '0);
        endcase
    end

    assign rem_dec   = best_rem_reg - TIN_W'(1);
    assign slice_inc = (best_idx_reg != cursor_reg) ? (QNT_W+1)'(1)
                                                     : (QNT_W+1)'(slice_reg) + (QNT_W+1)'(1);
    assign time_adv  = (sys_time_reg != TIME_MAX) ? sys_time_reg + NOW_W'(1) : sys_time_reg;

    always_comb
    begin
        state_next     = state_reg;
        policy_next    = policy_reg;
        quantum_next   = quantum_reg;
        ent_cnt_next   = ent_cnt_reg;
        unf_next       = unf_reg;
        sys_time_next  = sys_time_reg;
        cursor_next    = cursor_reg;
        slice_next     = slice_reg;
        scan_addr_next = scan_addr_reg;
        scan_cnt_next  = scan_cnt_reg;
        rd_valid_next  = 1'b0;
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_id_next   = best_id_reg;
        best_rem_next  = best_rem_reg;
        res_ev_next    = res_ev_reg;
        res_id_next    = res_id_reg;
        res_now_next   = res_now_reg;
        out_valid_next = out_valid_reg;
        out_ev_next    = out_ev_reg;
        out_id_next    = out_id_reg;
        out_now_next   = out_now_reg;
        load_we        = 1'b0;
        rem_we         = 1'b0;
        wr_addr        = best_idx_reg;
        rem_wdata      = rem_dec;
        rd_en          = 1'b0;

        if (cfg_we)
        begin
            case (paddr[2])
                REG_POLICY:  policy_next  = pwdata[POL_W-1:0];
                REG_QUANTUM: quantum_next = pwdata[QNT_W-1:0];
                default:     ;
            endcase
        end

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.mode)
                        MODE_LOAD:
                        begin
                            // A full table drops the load.
                            if (ent_cnt_reg < CNT_W'(MAX_PROCS))
                            begin
                                load_we      = 1'b1;
                                rem_wdata    = req.burst;
                                wr_addr      = ent_cnt_reg[IDX_W-1:0];
                                ent_cnt_next = ent_cnt_reg + CNT_W'(1);
                                if (req.burst != '0)
                                    unf_next = unf_reg + CNT_W'(1);
                            end
                        end
                        MODE_CLEAR:
                        begin
                            ent_cnt_next  = '0;
                            unf_next      = '0;
                            sys_time_next = '0;
                            cursor_next   = '0;
                            slice_next    = '0;
                        end
                        MODE_TICK:
                        begin
                            res_now_next = sys_time_reg;
                            res_id_next  = '0;
                            if (unf_reg == '0)
                            begin
                                // Nothing left to run: report all done, time holds.
                                res_ev_next = EV_ALLDONE;
                                state_next  = S_OUT;
                            end
                            else
                            begin
                                if (policy_reg == POL_RR)
                                begin
                                    cursor_next    = cur_prep;
                                    slice_next     = slice_prep;
                                    scan_addr_next = cur_prep;
                                end
                                else
                                begin
                                    scan_addr_next = '0;
                                end
                                scan_cnt_next = '0;
                                found_next    = 1'b0;
                                state_next    = S_SCAN;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            S_SCAN:
            begin
                // One table read is issued per cycle; the compare acts on the
                // data registered from the previous read.
                if (scan_issue)
                begin
                    rd_en          = 1'b1;
                    rd_valid_next  = 1'b1;
                    scan_addr_next = wrap_inc(scan_addr_reg, ent_cnt_reg);
                    scan_cnt_next  = scan_cnt_reg + CNT_W'(1);
                end
                if (rd_valid_reg && rd_take)
                begin
                    found_next    = 1'b1;
                    best_idx_next = rd_idx_reg;
                    best_id_next  = rd_id_reg;
                    best_rem_next = rd_rem_reg;
                end
                if (!scan_issue && !rd_valid_reg)
                    state_next = S_DEC;
            end

            S_DEC:
            begin
                if (!found_reg)
                begin
                    // Nothing runnable. Round robin and SRTF idle and time moves on;
                    // FCFS only gets here with every entry finished.
                    if (policy_reg == POL_RR || policy_reg == POL_SRTF)
                    begin
                        res_ev_next   = EV_IDLE;
                        sys_time_next = time_adv;
                    end
                    else
                    begin
                        res_ev_next = EV_ALLDONE;
                    end
                end
                else
                begin
                    rem_we        = 1'b1;
                    sys_time_next = time_adv;
                    res_id_next   = best_id_reg;
                    if (rem_dec == '0)
                    begin
                        res_ev_next = EV_FINISH;
                        if (unf_reg != '0)
                            unf_next = unf_reg - CNT_W'(1);
                    end
                    else
                    begin
                        res_ev_next = EV_RUN;
                    end
                    if (policy_reg == POL_RR)
                    begin
                        // A pick other than the cursor starts a fresh slice there.
                        if (rem_dec == '0 || slice_inc >= (QNT_W+1)'(q_eff))
                        begin
                            cursor_next = wrap_inc(best_idx_reg, ent_cnt_reg);
                            slice_next  = '0;
                        end
                        else
                        begin
                            cursor_next = best_idx_reg;
                            slice_next  = slice_inc[QNT_W-1:0];
                        end
                    end
                end
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ev_next    = res_ev_reg;
                    out_id_next    = res_id_reg;
                    out_now_next   = res_now_reg;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            policy_reg    <= POL_FCFS;
            quantum_reg   <= QNT_W'(1);
            ent_cnt_reg   <= '0;
            unf_reg       <= '0;
            sys_time_reg  <= '0;
            cursor_reg    <= '0;
            slice_reg     <= '0;
            scan_addr_reg <= '0;
            scan_cnt_reg  <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            best_idx_reg  <= '0;
            best_id_reg   <= '0;
            best_rem_reg  <= '0;
            res_ev_reg    <= EV_IDLE;
            res_id_reg    <= '0;
            res_now_reg   <= '0;
            out_valid_reg <= 1'b0;
            out_ev_reg    <= EV_IDLE;
            out_id_reg    <= '0;
            out_now_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            policy_reg    <= policy_next;
            quantum_reg   <= quantum_next;
            ent_cnt_reg   <= ent_cnt_next;
            unf_reg       <= unf_next;
            sys_time_reg  <= sys_time_next;
            cursor_reg    <= cursor_next;
            slice_reg     <= slice_next;
            scan_addr_reg <= scan_addr_next;
            scan_cnt_reg  <= scan_cnt_next;
            rd_valid_reg  <= rd_valid_next;
            found_reg     <= found_next;
            best_idx_reg  <= best_idx_next;
            best_id_reg   <= best_id_next;
            best_rem_reg  <= best_rem_next;
            res_ev_reg    <= res_ev_next;
            res_id_reg    <= res_id_next;
            res_now_reg   <= res_now_next;
            out_valid_reg <= out_valid_next;
            out_ev_reg    <= out_ev_next;
            out_id_reg    <= out_id_next;
            out_now_reg   <= out_now_next;
        end
    end

    // Process table: one write address and one registered read address per cycle.
    always_ff @(posedge clk)
    begin
        if (load_we)
        begin
            ids_mem[wr_addr] <= req.proc_id;
            arr_mem[wr_addr] <= req.arrival;
        end
        if (load_we || rem_we)
            rem_mem[wr_addr] <= rem_wdata;
        if (rd_en)
        begin
            rd_idx_reg <= scan_addr_reg;
            rd_id_reg  <= ids_mem[scan_addr_reg];
            rd_arr_reg <= arr_mem[scan_addr_reg];
            rd_rem_reg <= rem_mem[scan_addr_reg];
        end
    end

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ent_cnt_reg <= CNT_W'(MAX_PROCS))
        else $error("entry count exceeds table size");

    a_unf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        unf_reg <= ent_cnt_reg)
        else $error("unfinished count exceeds entry count");

    a_pick_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DEC && found_reg) |-> (CNT_W'(best_idx_reg) < ent_cnt_reg))
        else $error("picked entry lies outside the table");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result shown without a finished tick");
`endif

endmodule

### test/psched_tb_pkg.sv
package psched_tb_pkg;
    import psched_pkg::*;

    // One tick result as the scheduler reports it.
    typedef struct packed {
        logic [EV_W-1:0]  ev;
        logic [ID_W-1:0]  id;
        logic [NOW_W-1:0] now;
    } tick_report_t;

    // Mirrors the process table and predicts the report of every tick item.
    class tick_scoreboard;
        logic [ID_W-1:0]   proc_ids  [MAX_PROCS_DEF];
        logic [TIN_W-1:0]  arrive_at [MAX_PROCS_DEF];
        logic [TIN_W-1:0]  remain    [MAX_PROCS_DEF];
        bit                has_arrived [MAX_PROCS_DEF];
        int unsigned       entries;
        int unsigned       cursor;
        int unsigned       slice;
        int unsigned       unfinished;
        logic [NOW_W-1:0]  clock_now;
        logic [POL_W-1:0]  policy;
        logic [QNT_W-1:0]  quantum;
        tick_report_t      expected_ticks[$];
        int                errors;

        function new();
            clear_table();
            policy  = POL_FCFS;
            quantum = 1;
            errors  = 0;
        endfunction

        function void clear_table();
            for (int i = 0; i < MAX_PROCS_DEF; i++)
            begin
                proc_ids[i]    = '0;
                arrive_at[i]   = '0;
                remain[i]      = '0;
                has_arrived[i] = 1'b0;
            end
            entries    = 0;
            clock_now  = '0;
            cursor     = 0;
            slice      = 0;
            unfinished = 0;
        endfunction

        function void write_reg(logic idx, logic [DATA_W-1:0] data);
            if (idx == REG_POLICY)
                policy = data[POL_W-1:0];
            else
                quantum = data[QNT_W-1:0];
        endfunction

        function void advance();
            if (clock_now != TIME_MAX)
                clock_now = clock_now + 1'b1;
        endfunction

        function void rotate();
            cursor++;
            if (cursor >= entries)
                cursor = 0;
            slice = 0;
        endfunction

        function bit is_runnable(int unsigned i);
            return i < entries && remain[i] != 0 && has_arrived[i];
        endfunction

        function logic [EV_W-1:0] run_entry(int unsigned i);
            remain[i] = remain[i] - 1'b1;
            advance();
            if (remain[i] == 0)
            begin
                if (unfinished > 0)
                    unfinished--;
                return EV_FINISH;
            end
            return EV_RUN;
        endfunction

        function tick_report_t predict_tick();
            tick_report_t r;
            int unsigned  q;
            int unsigned  k;
            int unsigned  i;
            int unsigned  pick;
            bit           found;
            r.now = clock_now;
            r.id  = '0;
            r.ev  = EV_IDLE;
            found = 1'b0;
            pick  = 0;
            if (unfinished == 0)
            begin
                r.ev = EV_ALLDONE;
                return r;
            end
            for (i = 0; i < entries; i++)
                if (NOW_W'(arrive_at[i]) <= clock_now)
                    has_arrived[i] = 1'b1;
            if (policy == POL_RR)
            begin
                q = (quantum == 0) ? 1 : quantum;
                if (cursor >= entries)
                begin
                    cursor = 0;
                    slice  = 0;
                end
                if (slice >= q)
                    rotate();
                for (k = 0; k < entries && !found; k++)
                begin
                    i = cursor + k;
                    if (i >= entries)
                        i -= entries;
                    if (is_runnable(i))
                    begin
                        pick  = i;
                        found = 1'b1;
                    end
                end
                if (!found)
                begin
                    advance();
                    return r;
                end
                if (pick != cursor)
                begin
                    cursor = pick;
                    slice  = 0;
                end
                r.ev = run_entry(pick);
                slice++;
                if (r.ev == EV_FINISH || slice >= q)
                    rotate();
            end
            else if (policy == POL_SRTF)
            begin
                for (i = 0; i < entries; i++)
                    if (is_runnable(i) && (!found || remain[i] < remain[pick]))
                    begin
                        pick  = i;
                        found = 1'b1;
                    end
                if (!found)
                begin
                    advance();
                    return r;
                end
                r.ev = run_entry(pick);
            end
            else
            begin
                for (i = 0; i < entries && !found; i++)
                    if (remain[i] != 0)
                    begin
                        pick  = i;
                        found = 1'b1;
                    end
                if (!found)
                begin
                    r.ev = EV_ALLDONE;
                    return r;
                end
                r.ev = run_entry(pick);
            end
            r.id = proc_ids[pick];
            return r;
        endfunction

        // Notes an item accepted by the scheduler.
        function void accept_item(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                  logic [TIN_W-1:0] arrival, logic [TIN_W-1:0] burst);
            if (mode == MODE_LOAD)
            begin
                if (entries < MAX_PROCS_DEF)
                begin
                    proc_ids[entries]    = id;
                    arrive_at[entries]   = arrival;
                    remain[entries]      = burst;
                    has_arrived[entries] = 1'b0;
                    if (burst != 0)
                        unfinished++;
                    entries++;
                end
            end
            else if (mode == MODE_CLEAR)
                clear_table();
            else if (mode == MODE_TICK)
                expected_ticks.push_back(predict_tick());
        endfunction

        // Ticks needed to drain the table, with room for late arrivals.
        function int ticks_to_finish();
            int total;
            int late;
            total = 0;
            late  = 0;
            for (int i = 0; i < entries; i++)
            begin
                total += remain[i];
                if (NOW_W'(arrive_at[i]) > clock_now && int'(arrive_at[i]) - int'(clock_now) > late)
                    late = int'(arrive_at[i]) - int'(clock_now);
            end
            total += late + 2;
            return (total > 220) ? 220 : total;
        endfunction

        function int pending();
            return expected_ticks.size();
        endfunction

        function void check_tick(tick_report_t got);
            tick_report_t exp;
            if (expected_ticks.size() == 0)
            begin
                $error("tick result with none expected: event_res %0d run_id %0d now %0d",
                       got.ev, got.id, got.now);
                errors++;
                return;
            end
            exp = expected_ticks.pop_front();
            if (got.ev !== exp.ev)
            begin
                $error("event_res: expected %0d, actual %0d", exp.ev, got.ev);
                errors++;
            end
            if (got.id !== exp.id)
            begin
                $error("run_id: expected %0d, actual %0d", exp.id, got.id);
                errors++;
            end
            if (got.now !== exp.now)
            begin
                $error("now: expected %0d, actual %0d", exp.now, got.now);
                errors++;
            end
        endfunction
    endclass

endpackage

### test/tb_process_scheduler_tick.sv
module tb_process_scheduler_tick;
    import psched_pkg::*;
    import psched_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // A policy value of three has no name in the package; the block treats it as FCFS.
    localparam logic [POL_W-1:0] POL_FCFS_ALIAS = 2'd3;
    localparam logic [MODE_W-1:0] MODE_IGNORED  = 2'd3;

    localparam int NUM_PHASES     = 10;
    localparam int ITEMS_PER_PHASE = 55;

    // Every phase reprograms both registers and picks one idling pattern (phase mod 4).
    // The quantum runs from its reset value to its top, includes zero, and drops from
    // five to two between neighboring round robin phases so a running slice can be cut.
    logic [POL_W-1:0] phase_policy [NUM_PHASES] = '{POL_RR, POL_SRTF, POL_RR, POL_FCFS_ALIAS,
                                                   POL_RR, POL_RR, POL_SRTF, POL_RR,
                                                   POL_FCFS, POL_RR};
    int unsigned phase_quantum [NUM_PHASES] = '{1, 1, 65535, 7, 5, 2, 3, 0, 4, 65535};

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    psched_req_if req_ch ();
    psched_rsp_if rsp_ch ();

    process_scheduler_tick dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    tick_scoreboard sched_sb = new();

    // Percent chance, per cycle, that the sender holds back or the receiver stalls.
    int send_gap_pct = 0;
    int stall_pct    = 0;
    int items_sent   = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // The receiver redraws its ready at every falling edge, so stalls land on any
    // cycle of a tick, including the cycles where a result sits waiting.
    initial
    begin
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Results are taken at the rising edge at which valid and ready are both high.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sched_sb.check_tick('{ev: rsp_ch.event_res, id: rsp_ch.run_id, now: rsp_ch.now});
    end

    // Drives one item at a falling edge after an optional random gap, then waits for
    // the handshake. Valid stays high on return so back to back items need no bubble.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [ID_W-1:0] id,
                             input logic [TIN_W-1:0] arrival, input logic [TIN_W-1:0] burst);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid   = 1'b1;
        req_ch.mode    = mode;
        req_ch.proc_id = id;
        req_ch.arrival = arrival;
        req_ch.burst   = burst;
        do
            @(posedge clk);
        while (!req_ch.ready);
        sched_sb.accept_item(mode, id, arrival, burst);
        if (mode != MODE_IGNORED)
            items_sent++;
    endtask

    // A register write: setup cycle, then access cycle until pready. The upper bits of
    // the data are random, since the block keeps only the register's own width.
    task automatic apb_write(input logic idx, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sched_sb.write_reg(idx, data);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Lets every expected result come out, then allows for a load or clear that is
    // still in flight.
    task automatic wait_quiet();
        @(negedge clk);
        req_ch.valid = 1'b0;
        while (sched_sb.pending() != 0)
            @(posedge clk);
        repeat (MAX_PROCS_DEF + 16) @(posedge clk);
    endtask

    task automatic set_config(input logic [POL_W-1:0] pol, input int unsigned q);
        logic [DATA_W-1:0] junk;
        wait_quiet();
        junk = $urandom();
        apb_write(REG_POLICY, {junk[DATA_W-1:POL_W], pol});
        junk = $urandom();
        apb_write(REG_QUANTUM, {junk[DATA_W-1:QNT_W], QNT_W'(q)});
    endtask

    // One random sequence. Most are a clear, a handful of loads with early arrivals and
    // short bursts, and then enough ticks to run the table dry. A few fill the table
    // past its depth, a quarter stop early so the next one starts mid schedule, and a
    // small share is pure noise with every field random, including the ignored mode.
    task automatic run_sequence(input int clear_pct);
        int r;
        int n;
        int ticks;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            repeat ($urandom_range(1, 4))
                send_item(MODE_W'($urandom_range(0, 3)), ID_W'($urandom()),
                          TIN_W'($urandom()), TIN_W'($urandom()));
        end
        else
        begin
            if ($urandom_range(0, 99) < clear_pct)
                send_item(MODE_CLEAR, ID_W'($urandom()), TIN_W'($urandom()),
                          TIN_W'($urandom()));
            n = (r < 13) ? $urandom_range(60, 68) : $urandom_range(1, 8);
            repeat (n)
                send_item(MODE_LOAD, ID_W'($urandom_range(0, 65535)),
                          TIN_W'($urandom_range(0, 12)),
                          ($urandom_range(0, 9) == 0) ? '0 : TIN_W'($urandom_range(1, 5)));
            ticks = sched_sb.ticks_to_finish();
            if ($urandom_range(0, 3) == 0)
                ticks = $urandom_range(1, ticks);
            repeat (ticks)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_item(MODE_IGNORED, ID_W'($urandom()), TIN_W'($urandom()),
                              TIN_W'($urandom()));
                send_item(MODE_TICK, ID_W'($urandom()), TIN_W'($urandom()),
                          TIN_W'($urandom()));
            end
        end
    endtask

    initial
    begin
        int phase_start;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        req_ch.valid   = 1'b0;
        req_ch.mode    = MODE_LOAD;
        req_ch.proc_id = '0;
        req_ch.arrival = '0;
        req_ch.burst   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part under the reset settings (FCFS). A tick on an empty table
        // reports all done; the field extremes go into the loads; a zero burst entry
        // is stored finished; FCFS runs the late arrival at once; an ignored mode
        // gives no result; a clear brings the time back to zero.
        send_item(MODE_TICK, '0, '0, '0);
        send_item(MODE_LOAD, 16'hFFFF, 16'h0000, 16'd2);
        send_item(MODE_LOAD, 16'h0000, 16'hFFFF, 16'd0);
        send_item(MODE_LOAD, 16'h1234, 16'd5, 16'd1);
        send_item(MODE_IGNORED, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (4) send_item(MODE_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(MODE_LOAD, 16'hA5A5, 16'h7FFF, 16'hFFFF);
        repeat (2) send_item(MODE_TICK, '0, '0, '0);
        send_item(MODE_CLEAR, '0, '0, '0);
        send_item(MODE_TICK, '0, '0, '0);

        // Under SRTF nothing has arrived for the first two ticks, so they are idle
        // ticks that still advance the time; then the shorter job runs first.
        set_config(POL_SRTF, 1);
        send_item(MODE_LOAD, 16'd5, 16'd3, 16'd2);
        send_item(MODE_LOAD, 16'd6, 16'd2, 16'd1);
        repeat (6) send_item(MODE_TICK, '0, '0, '0);

        // Random phases. The table is not always cleared at the start of a phase, so
        // new register values can take effect in the middle of a schedule.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_config(phase_policy[p], phase_quantum[p]);
            case (p % 4)
                0:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 0;
                end
                1:
                begin
                    send_gap_pct = 80;
                    stall_pct    = 0;
                end
                2:
                begin
                    send_gap_pct = 0;
                    stall_pct    = 80;
                end
                default:
                begin
                    send_gap_pct = 10;
                    stall_pct    = 10;
                end
            endcase
            phase_start = items_sent;
            run_sequence(50);
            while (items_sent - phase_start < ITEMS_PER_PHASE)
                run_sequence(85);
        end

        wait_quiet();
        if (sched_sb.errors == 0 && sched_sb.pending() == 0)
            $display("process_scheduler_tick verification clean");
        else
            $display("process_scheduler_tick verification failed");
        $finish;
    end

    // Watchdog: far above the slowest legal run of this stimulus.
    initial
    begin
        #10ms;
        $display("process_scheduler_tick verification failed");
        $finish;
    end

endmodule
